// ----- rtl/thermostat_with_two_digit_display_assert.svh -----
// Assertion macros for the thermostat display block.
// Plain text, no dependencies; included by the top level.
`ifndef THERMOSTAT_WITH_TWO_DIGIT_DISPLAY_ASSERT_SVH
`define THERMOSTAT_WITH_TWO_DIGIT_DISPLAY_ASSERT_SVH

// Same-cycle implication, switched off while in reset.
`define TWD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("thermostat display: same-cycle check failed");

// Next-cycle implication, switched off while in reset.
`define TWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("thermostat display: next-cycle check failed");

`endif

// ----- rtl/twd_pkg.sv -----
// Package for the thermostat display: item types, codes, reset values, segment tables.
// No dependencies.
package twd_pkg;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] sensor_a;
    logic [3:0] sensor_b;
  } event_t;

  typedef struct packed {
    logic       digit_select;
    logic [6:0] segments;
    logic       heat_on;
    logic       cool_on;
    logic       program_lamp_on;
    logic       alarm;
  } result_t;

  typedef enum logic [2:0] {
    CMD_REFRESH   = 3'd0,
    CMD_HOUR_TICK = 3'd1,
    CMD_TOGGLE    = 3'd2,
    CMD_PLUS      = 3'd3,
    CMD_MINUS     = 3'd4,
    CMD_SAMPLE    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SETPOINT_MAX  = 3'd0,
    REG_SETPOINT_MIN  = 3'd1,
    REG_TICKS_PER_HR  = 3'd2,
    REG_NIGHT_START   = 3'd3,
    REG_NIGHT_END     = 3'd4,
    REG_MISMATCH_THR  = 3'd5
  } reg_idx_t;

  localparam int CFG_DATA_W = 7;

  localparam logic signed [6:0] SETPOINT_MAX_RST = 7'sd35;
  localparam logic signed [6:0] SETPOINT_MIN_RST = -7'sd9;
  localparam logic [5:0]        TICKS_PER_HR_RST = 6'd60;
  localparam logic [4:0]        NIGHT_START_RST  = 5'd22;
  localparam logic [4:0]        NIGHT_END_RST    = 5'd8;
  localparam logic [3:0]        MISMATCH_THR_RST = 4'd3;

  localparam logic signed [6:0] SETPOINT_RST = 7'sd12;
  localparam logic [4:0]        HOUR_RST     = 5'd9;
  localparam logic [4:0]        HOUR_WRAP    = 5'd24;

  // measured = 3*floor((a+b)/2) - 15
  localparam logic signed [6:0] MEAS_OFFSET = 7'sd15;
  localparam logic signed [6:0] NEG_SAT     = -7'sd9;
  localparam logic [3:0]        MAG_SAT     = 4'd9;

  localparam logic [6:0] SEG_MINUS = 7'h40;
  localparam logic [6:0] SEG_A     = 7'h77;
  localparam logic [6:0] SEG_L     = 7'h38;

  function automatic logic [6:0] digit_seg(logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7C;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h67;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // tens digit of a value below 64
  function automatic logic [3:0] tens_of(logic [5:0] u);
    logic [3:0] t;
    t = 4'd0;
    for (int i = 1; i <= 6; i++) begin
      if (u >= 6'(10 * i)) t = 4'(i);
    end
    return t;
  endfunction

  function automatic logic [3:0] units_of(logic [5:0] u);
    logic [5:0] tens10;
    tens10 = 6'({2'b00, tens_of(u)} * 6'd10);
    return 4'(u - tens10);
  endfunction

endpackage

// ----- rtl/thermostat_with_two_digit_display.sv -----
// Top level of the thermostat with two-digit display; uses twd_pkg and the
// assertion macros in thermostat_with_two_digit_display_assert.svh.
// Each event item (refresh, hour tick, program toggle, plus, minus, sensor
// sample) is accepted while evt_ready is high and folded into the state
// registers at that edge; a refresh item also yields one result item, put in
// the result register, or in the skid register while res is stalled. Rate is
// one item per clock while evt_ready is high: the event decode and the display
// selection are a single short level of logic between the state registers and
// the result register. A one-entry skid register behind the result register
// lets events keep flowing while a result waits; evt_ready drops only when both
// hold a result. Configuration writes land at once on cfg_write with cfg_index
// naming the register; they are meant for idle periods only. Sensor samples give
// measured = 3*floor((a+b)/2) - 15 and raise the alarm when |a-b| reaches the
// threshold. Negative values show a minus and a magnitude saturated at 9.
`include "thermostat_with_two_digit_display_assert.svh"

module thermostat_with_two_digit_display (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              evt_valid,
  output logic                              evt_ready,
  input  twd_pkg::event_t                   evt,
  output logic                              res_valid,
  input  logic                              res_ready,
  output twd_pkg::result_t                  res,
  input  logic                              cfg_write,
  input  logic [2:0]                        cfg_index,
  input  logic [twd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import twd_pkg::*;

  // configuration registers
  logic signed [6:0] setpoint_max;
  logic signed [6:0] setpoint_min;
  logic [5:0]        ticks_per_hour;
  logic [4:0]        night_start_hour;
  logic [4:0]        night_end_hour;
  logic [3:0]        mismatch_threshold;

  // thermostat state
  logic signed [6:0] setpoint, setpoint_next;
  logic signed [5:0] measured, measured_next;
  logic              mismatch_flag, mismatch_flag_next;
  logic              program_mode, program_mode_next;
  logic              program_lamp, program_lamp_next;
  logic [4:0]        hour, hour_next;
  logic [5:0]        tick_count, tick_count_next;
  logic              night, night_next;
  logic              digit_phase, digit_phase_next;

  // result buffering
  result_t res_q, skid_q, result;
  logic    skid_valid;

  logic evt_fire;
  logic refresh_fire;

  assign evt_ready    = !skid_valid;
  assign evt_fire     = evt_valid && evt_ready;
  assign refresh_fire = evt_fire && (evt.command == CMD_REFRESH);

  // --- configuration port ---
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_max       <= SETPOINT_MAX_RST;
      setpoint_min       <= SETPOINT_MIN_RST;
      ticks_per_hour     <= TICKS_PER_HR_RST;
      night_start_hour   <= NIGHT_START_RST;
      night_end_hour     <= NIGHT_END_RST;
      mismatch_threshold <= MISMATCH_THR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SETPOINT_MAX: setpoint_max       <= cfg_data[6:0];
        REG_SETPOINT_MIN: setpoint_min       <= cfg_data[6:0];
        REG_TICKS_PER_HR: ticks_per_hour     <= cfg_data[5:0];
        REG_NIGHT_START:  night_start_hour   <= cfg_data[4:0];
        REG_NIGHT_END:    night_end_hour     <= cfg_data[4:0];
        REG_MISMATCH_THR: mismatch_threshold <= cfg_data[3:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // --- event arithmetic ---
  logic [6:0]        tick_inc;
  logic [5:0]        hour_inc;
  logic [4:0]        hour_adv;
  logic signed [7:0] sp_inc, sp_dec;
  logic [4:0]        sens_sum;
  logic [3:0]        sens_half;
  logic [5:0]        sens_tri;
  logic signed [6:0] meas_calc;
  logic [3:0]        sens_diff;

  assign tick_inc  = {1'b0, tick_count} + 7'd1;
  assign hour_inc  = {1'b0, hour} + 6'd1;
  assign hour_adv  = (hour_inc > {1'b0, HOUR_WRAP}) ? 5'd0 : hour_inc[4:0];
  assign sp_inc    = {setpoint[6], setpoint} + 8'sd1;
  assign sp_dec    = {setpoint[6], setpoint} - 8'sd1;
  assign sens_sum  = {1'b0, evt.sensor_a} + {1'b0, evt.sensor_b};
  assign sens_half = sens_sum[4:1];
  assign sens_tri  = {1'b0, sens_half, 1'b0} + {2'b00, sens_half};
  assign meas_calc = $signed({1'b0, sens_tri}) - MEAS_OFFSET;
  assign sens_diff = (evt.sensor_a >= evt.sensor_b) ? (evt.sensor_a - evt.sensor_b)
                                                    : (evt.sensor_b - evt.sensor_a);

  // --- display selection, from the state before this item ---
  logic signed [6:0] meas_ext;
  logic signed [6:0] shown;
  logic signed [6:0] shown_neg;
  logic [3:0]        neg_mag;
  logic [6:0]        seg_value;
  logic              disp_blank;  // night, or alarm outside program mode: fixed text, lamps dark

  assign meas_ext  = {measured[5], measured};
  assign shown     = program_mode ? setpoint : meas_ext;
  assign shown_neg = -shown;
  assign neg_mag   = (shown < NEG_SAT) ? MAG_SAT : shown_neg[3:0];
  assign disp_blank = night || (!program_mode && mismatch_flag);

  always_comb begin
    if (shown[6]) begin
      seg_value = digit_phase ? digit_seg(neg_mag) : SEG_MINUS;
    end else begin
      seg_value = digit_phase ? digit_seg(units_of(shown[5:0]))
                              : digit_seg(tens_of(shown[5:0]));
    end
  end

  always_comb begin
    result.digit_select    = digit_phase;
    result.heat_on         = 1'b0;
    result.cool_on         = 1'b0;
    result.program_lamp_on = disp_blank ? 1'b0 : program_lamp;
    result.alarm           = mismatch_flag;
    if (night) begin
      result.segments = digit_phase ? digit_seg(4'd2) : digit_seg(4'd1);
    end else if (!program_mode && mismatch_flag) begin
      result.segments = digit_phase ? SEG_L : SEG_A;
    end else begin
      result.segments = seg_value;
      result.heat_on  = setpoint > meas_ext;
      result.cool_on  = setpoint < meas_ext;
    end
  end

  // --- next state ---
  always_comb begin
    setpoint_next      = setpoint;
    measured_next      = measured;
    mismatch_flag_next = mismatch_flag;
    program_mode_next  = program_mode;
    program_lamp_next  = program_lamp;
    hour_next          = hour;
    tick_count_next    = tick_count;
    night_next         = night;
    digit_phase_next   = digit_phase;
    if (evt_fire) begin
      case (evt.command)
        CMD_REFRESH: begin
          program_lamp_next = result.program_lamp_on;
          digit_phase_next  = !digit_phase;
        end
        CMD_HOUR_TICK: begin
          // hour advances and night is re-evaluated only on rollover
          if (tick_inc >= {1'b0, ticks_per_hour}) begin
            tick_count_next = 6'd0;
            hour_next       = hour_adv;
            night_next      = (hour_adv >= night_start_hour) || (hour_adv <= night_end_hour);
          end else begin
            tick_count_next = tick_inc[5:0];
          end
        end
        CMD_TOGGLE: begin
          program_mode_next = !program_mode;
          program_lamp_next = !program_mode;
        end
        CMD_PLUS: begin
          if (program_mode) begin
            setpoint_next = (sp_inc > $signed({setpoint_max[6], setpoint_max})) ? setpoint_max
                                                                                 : sp_inc[6:0];
          end
        end
        CMD_MINUS: begin
          if (program_mode) begin
            setpoint_next = (sp_dec < $signed({setpoint_min[6], setpoint_min})) ? setpoint_min
                                                                                 : sp_dec[6:0];
          end
        end
        CMD_SAMPLE: begin
          measured_next      = meas_calc[5:0];
          mismatch_flag_next = sens_diff >= mismatch_threshold;
        end
        default: ;  // unused codes are swallowed
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= SETPOINT_RST;
      measured      <= 6'sd0;
      mismatch_flag <= 1'b0;
      program_mode  <= 1'b0;
      program_lamp  <= 1'b0;
      hour          <= HOUR_RST;
      tick_count    <= 6'd0;
      night         <= 1'b0;
      digit_phase   <= 1'b0;
    end else begin
      setpoint      <= setpoint_next;
      measured      <= measured_next;
      mismatch_flag <= mismatch_flag_next;
      program_mode  <= program_mode_next;
      program_lamp  <= program_lamp_next;
      hour          <= hour_next;
      tick_count    <= tick_count_next;
      night         <= night_next;
      digit_phase   <= digit_phase_next;
    end
  end

  // --- result register with skid entry ---
  // skid only fills when a refresh lands while the result register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (res_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid && !res_ready) begin
      if (refresh_fire) begin
        skid_valid <= 1'b1;
      end
    end else begin
      res_valid <= refresh_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (res_ready) begin
        res_q <= skid_q;
      end
    end else if (res_valid && !res_ready) begin
      if (refresh_fire) begin
        skid_q <= result;
      end
    end else if (refresh_fire) begin
      res_q <= result;
    end
  end

  assign res = res_q;

  // --- checks ---
  `TWD_ASSERT_NOW(a_skid_behind_res, clk, rst, skid_valid, res_valid)
  `TWD_ASSERT_NOW(a_hour_in_range, clk, rst, 1'b1, hour <= HOUR_WRAP)
  `TWD_ASSERT_NEXT(a_phase_flips, clk, rst, refresh_fire, digit_phase != $past(digit_phase))
  `TWD_ASSERT_NEXT(a_no_spurious_res, clk, rst, !res_valid && !refresh_fire, !res_valid)

endmodule
